[rtl/assert_macros.svh]
// Assertion macros used by the checker file krgt_checker.sv.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

[rtl/krgt_pkg.sv]
// Package for the keyed reference count table: sizes, codes and shared types.
// Used by every module of the block; depends on nothing.
package krgt_pkg;

   localparam int SLOTS         = 4;
   localparam int COUNT_BITS    = 8;
   localparam int BOARD_BITS    = 8;
   localparam int PORT_BITS     = 8;
   localparam int SLOT_IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int FIELD_BITS    = 8;

   localparam logic [1:0] REQ_ACQUIRE = 2'd0;
   localparam logic [1:0] REQ_RELEASE = 2'd1;
   localparam logic [1:0] REQ_QUERY   = 2'd2;
   localparam logic [1:0] REQ_SPARE   = 2'd3;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_SATURATED = 2'd2;
   localparam logic [1:0] STATUS_NO_REF    = 2'd3;

   typedef logic [SLOT_IDX_BITS-1:0] slot_idx_type;

   typedef struct packed {
      logic         hit;
      slot_idx_type hit_idx;
      logic         free;
      slot_idx_type free_idx;
   } match_type;

   typedef struct packed {
      logic                  needed;
      logic [FIELD_BITS-1:0] ref_count;
      logic [1:0]            status;
   } result_type;

   function automatic logic [FIELD_BITS-1:0] count_to_field(
      input logic [COUNT_BITS-1:0] cnt
   );
      logic [COUNT_BITS+FIELD_BITS-1:0] wide;
      wide = {{FIELD_BITS{1'b0}}, cnt};
      return wide[FIELD_BITS-1:0];
   endfunction

endpackage

[rtl/krgt_match.sv]
// Parallel key compare and free slot search for the reference count table.
// Depends on krgt_pkg.
module krgt_match
   import krgt_pkg::*;
(
   input  logic [SLOTS-1:0]                 slot_used,
   input  logic [SLOTS-1:0][BOARD_BITS-1:0] slot_board,
   input  logic [SLOTS-1:0][PORT_BITS-1:0]  slot_port,
   input  logic [BOARD_BITS-1:0]            board_number,
   input  logic [PORT_BITS-1:0]             port_number,
   output match_type                        match
);

   always_comb begin
      match = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (slot_used[i] && slot_board[i] == board_number
             && slot_port[i] == port_number) begin
            match.hit     = 1'b1;
            match.hit_idx = SLOT_IDX_BITS'(i);
         end
         if (!slot_used[i]) begin
            match.free     = 1'b1;
            match.free_idx = SLOT_IDX_BITS'(i);
         end
      end
   end

endmodule

[rtl/krgt_table.sv]
// Slot storage and single-pass update of the reference count table.
// Depends on krgt_pkg and krgt_match.
module krgt_table
   import krgt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  upd_en,
   input  logic [1:0]            req_type,
   input  logic [BOARD_BITS-1:0] board_number,
   input  logic [PORT_BITS-1:0]  port_number,
   output result_type            result
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [SLOTS-1:0]                 used_ff;
   logic [SLOTS-1:0][BOARD_BITS-1:0] board_ff;
   logic [SLOTS-1:0][PORT_BITS-1:0]  port_ff;
   logic [COUNT_BITS-1:0]            count_ff [SLOTS];

   match_type             match;
   logic                  wr_en;
   slot_idx_type          wr_idx;
   logic [COUNT_BITS-1:0] cur_count;
   logic [COUNT_BITS-1:0] count_in;
   logic [1:0]            status;

   krgt_match u_match (
      .slot_used    (used_ff),
      .slot_board   (board_ff),
      .slot_port    (port_ff),
      .board_number (board_number),
      .port_number  (port_number),
      .match        (match)
   );

   always_comb begin
      wr_en     = 1'b0;
      wr_idx    = match.hit ? match.hit_idx : match.free_idx;
      cur_count = match.hit ? count_ff[match.hit_idx] : '0;
      count_in  = cur_count;
      status    = STATUS_DONE;
      unique case (req_type)
         REQ_ACQUIRE: begin
            if (!match.hit && !match.free) begin
               status = STATUS_FULL;
            end else begin
               wr_en = 1'b1;
               if (cur_count == COUNT_MAX) begin
                  status = STATUS_SATURATED;
               end else begin
                  count_in = cur_count + COUNT_BITS'(1);
               end
            end
         end
         REQ_RELEASE: begin
            if (match.hit && cur_count != '0) begin
               wr_en    = 1'b1;
               count_in = cur_count - COUNT_BITS'(1);
            end else begin
               status = STATUS_NO_REF;
            end
         end
         REQ_QUERY, REQ_SPARE: begin
            status = STATUS_DONE;
         end
         default: begin
            status = STATUS_DONE;
         end
      endcase
      result.needed    = (count_in != '0);
      result.ref_count = count_to_field(count_in);
      result.status    = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            count_ff[i] <= '0;
         end
      end else if (upd_en && wr_en) begin
         used_ff[wr_idx]  <= 1'b1;
         count_ff[wr_idx] <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_en && wr_en) begin
         board_ff[wr_idx] <= board_number;
         port_ff[wr_idx]  <= port_number;
      end
   end

endmodule

[rtl/keyed_refcount_gate_table_top.sv]
// A request is taken into the input register, and its result then into the response register.
// Throughput: one request per cycle while the response is not stalled; the table updates in one pass per request.
// A stalled response holds the input register, so one more request is buffered.
// Reset (synchronous, active high) clears the valid flags, all slot used flags and counts.
// Top level of the keyed reference count table. Depends on krgt_pkg, krgt_table.
module keyed_refcount_gate_table_top
   import krgt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // board_number[7:0], port_number[15:8]
   input  logic [1:0]  req_tuser,  // req_type[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // needed[0], ref_count[8:1], status[10:9], zero[15:11]
);

   logic                  in_valid_ff;
   logic [1:0]            in_type_ff;
   logic [BOARD_BITS-1:0] in_board_ff;
   logic [PORT_BITS-1:0]  in_port_ff;
   logic                  rsp_valid_ff;
   result_type            rsp_ff;
   result_type            result;
   logic                  advance;
   logic                  in_valid_in;

   assign advance     = !rsp_valid_ff || rsp_tready;
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   krgt_table u_table (
      .clock        (clock),
      .reset        (reset),
      .upd_en       (in_valid_ff && advance),
      .req_type     (in_type_ff),
      .board_number (in_board_ff),
      .port_number  (in_port_ff),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_type_ff  <= req_tuser;
         in_board_ff <= req_tdata[BOARD_BITS-1:0];
         in_port_ff  <= req_tdata[8 +: PORT_BITS];
      end
      if (advance && in_valid_ff) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_ff.status, rsp_ff.ref_count, rsp_ff.needed};

endmodule

[rtl/krgt_checker.sv]
// Port-level checker for the keyed reference count table, bound to the top.
// Depends on krgt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module krgt_checker
   import krgt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_tvalid)
   `ASSERT_CLK(a_ready_when_drained, clock, reset, !rsp_tvalid |-> req_tready)
   `ASSERT_CLK(a_full_is_empty, clock, reset, rsp_tvalid && rsp_tdata[10:9] == STATUS_FULL |-> rsp_tdata[8:0] == 9'd0)

endmodule

bind keyed_refcount_gate_table_top krgt_checker u_krgt_checker (.*);
